>>> rtl/fisa_pkg.sv
// Shared types and constants for the free ID stack allocator.
// No dependencies; the top level takes everything here by scoped names.
package fisa_pkg;

	// number of IDs the stack can hold
	localparam int MAX_SLOTS = 256;

	// stack pointer counts 0..MAX_SLOTS, table address covers 0..MAX_SLOTS-1
	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int ADDR_W = $clog2(MAX_SLOTS);

	// field widths on the ports
	localparam int ID_W     = 9;
	localparam int LIMIT_W  = 9;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 16;

	// all ones stands for "no ID"
	localparam logic [ID_W-1:0] ID_NONE = '1;

	typedef enum logic {
		MODE_ACQUIRE = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

endpackage

>>> rtl/free_id_stack_allocator.sv
// Free ID stack allocator: free IDs in one synchronous memory plus a cached top entry;
// depends on fisa_pkg for widths and codes.
// Each result is registered and shows on the master side in the cycle after its input.
// Throughput: one transaction per cycle unless m_tready stalls; the entry above the
// next pointer is prefetched every cycle so the cached top is always current.
// Reset and a limit write restore entry i to i at once via a high-water mark.
module free_id_stack_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fisa_pkg::LIMIT_W-1:0]  cfg_data,   // slot_limit
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fisa_pkg::DATA_W-1:0]   s_tdata,    // [8:0] release_id, rest zero
	input  logic [0:0]                    s_tuser,    // [0] mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fisa_pkg::DATA_W-1:0]   m_tdata,    // [8:0] granted_id, rest zero
	output logic [fisa_pkg::STATUS_W-1:0] m_tuser     // [1:0] status
);

	localparam int SLOT_W = fisa_pkg::SLOT_W;
	localparam int ADDR_W = fisa_pkg::ADDR_W;
	localparam int ID_W   = fisa_pkg::ID_W;

	logic [ID_W-1:0]   free_ids_q [fisa_pkg::MAX_SLOTS];
	logic [ID_W-1:0]   rd_s1;

	logic [SLOT_W-1:0] top_q, top_d;
	logic [SLOT_W-1:0] hwm_q, hwm_d;
	logic [SLOT_W-1:0] limit_q, limit_d;
	logic [ID_W-1:0]   top_val_q, top_val_d;

	logic                         out_valid_q;
	logic [ID_W-1:0]              out_id_q;
	fisa_pkg::status_t            out_status_q;

	logic                 accept;
	logic                 is_acq;
	logic [ID_W-1:0]      rid;
	logic [SLOT_W-1:0]    top_p1;
	logic [ID_W-1:0]      above_val;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [ID_W-1:0]      mem_wdata;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [SLOT_W-1:0]    raddr_full;
	logic [ID_W-1:0]      res_id;
	fisa_pkg::status_t    res_status;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_acq   = (fisa_pkg::mode_t'(s_tuser[0]) == fisa_pkg::MODE_ACQUIRE);
	assign rid      = s_tdata[ID_W-1:0];

	// entry just above the pointer: memory data if ever written, else its index
	assign top_p1    = top_q + SLOT_W'(1);
	assign above_val = (top_p1 < hwm_q) ? rd_s1 : ID_W'(top_p1);

	// clamp the written limit to 1..MAX_SLOTS
	always_comb begin
		if (32'(cfg_data) > 32'(fisa_pkg::MAX_SLOTS)) begin
			limit_d = SLOT_W'(fisa_pkg::MAX_SLOTS);
		end else if (cfg_data == '0) begin
			limit_d = SLOT_W'(1);
		end else begin
			limit_d = SLOT_W'(cfg_data);
		end
	end

	always_comb begin
		top_d      = top_q;
		hwm_d      = hwm_q;
		top_val_d  = top_val_q;
		mem_we     = 1'b0;
		mem_waddr  = ADDR_W'(top_q);
		mem_wdata  = top_val_q;
		res_id     = fisa_pkg::ID_NONE;
		res_status = fisa_pkg::ST_DONE;
		if (cfg_we) begin
			top_d     = '0;
			hwm_d     = '0;
			top_val_d = '0;
		end else if (accept) begin
			if (is_acq) begin
				if (top_q < limit_q) begin
					// write back the granted entry so everything below hwm is real
					res_id    = top_val_q;
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(top_q);
					mem_wdata = top_val_q;
					top_d     = top_p1;
					top_val_d = above_val;
					if (top_q == hwm_q) begin
						hwm_d = top_p1;
					end
				end else begin
					res_status = fisa_pkg::ST_EMPTY;
				end
			end else begin
				if (top_q != '0 && rid != fisa_pkg::ID_NONE) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(top_q - SLOT_W'(1));
					mem_wdata = rid;
					top_d     = top_q - SLOT_W'(1);
					top_val_d = rid;
				end else begin
					res_status = fisa_pkg::ST_IGNORED;
				end
			end
		end
	end

	// prefetch the entry above the next pointer; never the entry written now
	assign raddr_full = top_d + SLOT_W'(1);
	assign mem_raddr  = raddr_full[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			free_ids_q[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= free_ids_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			hwm_q     <= '0;
			top_val_q <= '0;
			limit_q   <= SLOT_W'(fisa_pkg::MAX_SLOTS);
		end else begin
			top_q     <= top_d;
			hwm_q     <= hwm_d;
			top_val_q <= top_val_d;
			if (cfg_we) begin
				limit_q <= limit_d;
			end
		end
	end

	// output register: hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_id_q     <= res_id;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(fisa_pkg::DATA_W - ID_W){1'b0}}, out_id_q};
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	a_top_below_hwm : assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= hwm_q) else $error("stack pointer above high-water mark");

	a_top_within_limit : assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= limit_q) else $error("stack pointer beyond slot limit");

	a_limit_range : assert property (@(posedge clk) disable iff (!arst_n)
		limit_q != '0 && 32'(limit_q) <= 32'(fisa_pkg::MAX_SLOTS))
		else $error("slot limit out of range");

	a_fail_no_id : assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_status != fisa_pkg::ST_DONE |=> m_tdata[ID_W-1:0] == fisa_pkg::ID_NONE)
		else $error("failed transaction carries an ID");
`endif

endmodule
